[src/cdq_pkg.sv]
// Package for the circular deque: request codes, status codes and the
// command word from the controller to the datapath. No dependencies.
package cdq_pkg;

   // Request codes carried on req_type.
   localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
   localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
   localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
   localparam logic [1:0] REQ_POP_REAR   = 2'd3;

   // Status codes returned on rsp_status.
   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request word and read the ring
      logic execute;   // update indices, write the ring, register the result
   } cdq_cmd_type;

endpackage

[src/cdq_ctrl.sv]
// Controller of the circular deque: a two-state machine that sequences one
// request through capture and execute. Depends on cdq_pkg.
module cdq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output cdq_pkg::cdq_cmd_type cmd
);
   import cdq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   // A request is taken whenever the machine is idle.
   assign busy        = (state_ff == ST_EXEC);
   assign cmd.capture = start && !busy;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign rsp_valid   = rsp_valid_ff;

   // Next state: every accepted request passes through the execute state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and the result strobe, which follows the execute cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_EXEC);
      end
   end

endmodule

[src/cdq_datapath.sv]
// Datapath of the circular deque: the ring memory, head and tail indices,
// the empty flag and the result registers. Depends on cdq_pkg.
module cdq_datapath #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cdq_pkg::cdq_cmd_type cmd,
   input  logic [1:0]           req_type,
   input  logic signed [31:0]   req_push_value,
   output logic [1:0]           rsp_status,
   output logic signed [31:0]   rsp_popped_value,
   output logic                 rsp_now_empty,
   output logic                 rsp_now_full
);
   import cdq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam logic [IW-1:0] LAST_INDEX = IW'(DEPTH - 1);

   // Ring memory and its registered read port.
   logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Request held from capture to execute.
   logic [1:0]            req_type_ff;
   logic [DATA_WIDTH-1:0] word_ff;

   // Deque state.
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic          empty_ff, empty_in;

   // Result registers.
   logic [1:0]         status_ff, status_in;
   logic signed [31:0] popped_ff, popped_in;
   logic               now_empty_ff;
   logic               now_full_ff, full_in;

   logic [IW-1:0]         rd_addr;
   logic [IW-1:0]         wr_addr;
   logic                  wr_en;
   logic                  full_now;
   logic [63:0]           push_ext;
   logic [63:0]           rd_ext;
   logic [DATA_WIDTH-1:0] word_in;

   // Index steps that wrap at either end of the ring.
   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
      return (idx == LAST_INDEX) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] idx);
      return (idx == '0) ? LAST_INDEX : idx - 1'b1;
   endfunction

   // The pushed word is kept as its low DATA_WIDTH bits; a popped word is
   // returned zero-extended or cut to 32 bits.
   assign push_ext = {32'b0, req_push_value};
   assign word_in  = push_ext[DATA_WIDTH-1:0];
   assign rd_ext   = 64'(rd_data_ff);

   // Pop rear reads at the tail, everything else at the head.
   assign rd_addr = (req_type == REQ_POP_REAR) ? tail_ff : head_ff;

   assign full_now = !empty_ff && (head_ff == wrap_inc(tail_ff));

   // Execute step: work out new indices, the write and the result.
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      status_in = STATUS_DONE;
      popped_in = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      if (!req_type_ff[1]) begin
         if (full_now) begin
            status_in = STATUS_OVERFLOW;
         end else if (empty_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b0;
            wr_en    = 1'b1;
            wr_addr  = '0;
         end else if (req_type_ff == REQ_PUSH_FRONT) begin
            head_in = wrap_dec(head_ff);
            wr_en   = 1'b1;
            wr_addr = wrap_dec(head_ff);
         end else begin
            tail_in = wrap_inc(tail_ff);
            wr_en   = 1'b1;
            wr_addr = wrap_inc(tail_ff);
         end
      end else begin
         if (empty_ff) begin
            status_in = STATUS_EMPTY;
         end else begin
            popped_in = $signed(rd_ext[31:0]);
            if (head_ff == tail_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b1;
            end else if (req_type_ff == REQ_POP_FRONT) begin
               head_in = wrap_inc(head_ff);
            end else begin
               tail_in = wrap_dec(tail_ff);
            end
         end
      end
      full_in = !empty_in && (head_in == wrap_inc(tail_in));
   end

   // Ring memory: one write and one registered read.
   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) begin
         ring_mem[wr_addr] <= word_ff;
      end
      if (cmd.capture) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   // Request and result registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         word_ff     <= word_in;
      end
      if (cmd.execute) begin
         status_ff    <= status_in;
         popped_ff    <= popped_in;
         now_empty_ff <= empty_in;
         now_full_ff  <= full_in;
      end
   end

   // Indices and the empty flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (cmd.execute) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_now_empty    = now_empty_ff;
   assign rsp_now_full     = now_full_ff;

endmodule

[src/circular_deque_top.sv]
// Circular deque of DEPTH words, each DATA_WIDTH bits wide.
// Requests push at the front or rear, or pop from the front or rear.
//
// Request channel: a word (req_type, req_push_value) is taken at a rising
// edge where start is high and busy is low. busy stays high for the
// execute cycle that follows.
// Result channel: exactly one result word per request, shown for one cycle
// with rsp_valid high: rsp_status, rsp_popped_value, rsp_now_empty and
// rsp_now_full. The receiver cannot stall; it must take the word then.
// Sequence: the accepting edge enters the execute state, and the edge that
// ends it raises rsp_valid; no new request is taken while busy is high. The
// accepting edge also does the ring memory's registered read; the execute
// cycle that follows updates the indices and writes.
// Reset (synchronous, active high) empties the deque and returns both
// indices to zero; the ring contents are not cleared and are never returned
// before they are written.
// Depends on cdq_pkg, cdq_ctrl and cdq_datapath.
module circular_deque_top #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_popped_value,
   output logic               rsp_now_empty,
   output logic               rsp_now_full
);
   import cdq_pkg::*;

   cdq_cmd_type cmd;

   // Sequencing of each request.
   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Ring, indices and result registers.
   cdq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (req_type),
      .req_push_value   (req_push_value),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_now_empty    (rsp_now_empty),
      .rsp_now_full     (rsp_now_full)
   );

   // An accepted request occupies the execute cycle next.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not enter execute");

   // The execute cycle is always followed by exactly one result.
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("execute cycle produced no result");

   // The deque can never be both empty and full.
   a_empty_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_now_empty && rsp_now_full))
      else $error("result reports empty and full together");

   // A refused pop leaves the deque empty; a refused push leaves it full.
   a_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status != STATUS_EMPTY || rsp_now_empty) &&
                     (rsp_status != STATUS_OVERFLOW || rsp_now_full)))
      else $error("refused request with inconsistent occupancy");

endmodule
